FILE: sv/dnsq_pkg.sv
// Shared constants, types and helper functions of the dither and noise-shaping quantizer.
package dnsq_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DITHER_W   = 20;
  localparam int GAIN_W     = 23;
  localparam int GAIN_FRAC  = 8;
  localparam int LIMIT_W    = GAIN_W - GAIN_FRAC;
  localparam int RATE_W     = 2;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int TAP_COUNT  = 9;
  localparam int TAP_W      = $clog2(TAP_COUNT);
  localparam int FRAC_BITS  = 16;
  localparam int COEF_BITS  = 16;
  localparam int PROD_SHIFT = 30 - FRAC_BITS;

  localparam int ERR_W   = 18;
  localparam int FB_W    = 24;
  localparam int XW      = 36;
  localparam int ACC_W   = 40;
  localparam int COEF_W  = 20;
  localparam int R_W     = 20;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // The dither divide by one million is split into a shift by 64 and a divide by 15625.
  localparam int DITH_SUM_W     = DITHER_W + 1;
  localparam int DITH_PRE       = FRAC_BITS - 6;
  localparam int DITH_BIAS      = 500000 >> 6;
  localparam int DITH_DIVISOR   = 1000000 >> 6;
  localparam int DITH_M_W       = DITH_SUM_W + DITH_PRE + 1;
  localparam int DITH_RCP_SHIFT = DITH_M_W;
  localparam longint unsigned DITH_RECIP = (64'd1 << DITH_RCP_SHIFT) / DITH_DIVISOR;
  localparam int DITH_Q_W       = 18;
  localparam int DITH_ONE       = 1 << FRAC_BITS;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LIMIT = 24'sd5033165;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 23'd8388352;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

  localparam logic [RATE_W-1:0] RATE_441  = 2'd0;
  localparam logic [RATE_W-1:0] RATE_48   = 2'd1;
  localparam logic [RATE_W-1:0] RATE_NONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NS_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DITH_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE    = 3'd3;

  localparam logic signed [COEF_W-1:0] COEF_441 [TAP_COUNT] = '{
    -20'sd4545, 20'sd34433, -20'sd78995, 20'sd137247, -20'sd210878,
    20'sd265324, -20'sd251575, 20'sd216652, -20'sd156423
  };
  localparam logic signed [COEF_W-1:0] COEF_48 [TAP_COUNT] = '{
    20'sd12894, -20'sd19717, 20'sd6275, 20'sd38148, -20'sd123588,
    20'sd221070, -20'sd254330, 20'sd234985, -20'sd166680
  };

  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_S,
    ST_DIV_K,
    ST_DIV_C,
    ST_DITH,
    ST_RND,
    ST_MAC,
    ST_MAC_TAIL,
    ST_FB,
    ST_DONE
  } st_e;

  typedef struct packed {
    st_e               st;
    logic              lane;
    logic [TAP_W-1:0]  tap;
  } ctl_t;

  // Arithmetic shift right by s with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< (s - 1);
    if (v < 0) begin
      bias = bias - 64'sd1;
    end
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [RATE_W-1:0] rate,
                                                       input logic [TAP_W-1:0] tap);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (tap <= TAP_LAST) begin
      case (rate)
        RATE_441: c = COEF_441[tap];
        RATE_48:  c = COEF_48[tap];
        default:  c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: sv/dnsq_if.sv
// Handshake interfaces for the frame, result and configuration channels.
interface dnsq_frame_if;
  import dnsq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [DITHER_W-1:0]        left_dither_a;
  logic [DITHER_W-1:0]        left_dither_b;
  logic [DITHER_W-1:0]        right_dither_a;
  logic [DITHER_W-1:0]        right_dither_b;
  logic                       block_end;

  modport source (
    output valid, left_sample, right_sample, left_dither_a, left_dither_b,
           right_dither_a, right_dither_b, block_end,
    input  ready
  );
  modport sink (
    input  valid, left_sample, right_sample, left_dither_a, left_dither_b,
           right_dither_a, right_dither_b, block_end,
    output ready
  );
endinterface

interface dnsq_result_if;
  import dnsq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_out;
  logic signed [OUT_W-1:0] right_out;
  logic                    frame_last;

  modport source (output valid, left_out, right_out, frame_last, input ready);
  modport sink (input valid, left_out, right_out, frame_last, output ready);
endinterface

interface dnsq_cfg_if;
  import dnsq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dnsq_mul.sv
// Shared signed multiplier with a registered product.
module dnsq_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [dnsq_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [dnsq_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [dnsq_pkg::MUL_P_W-1:0]  p_o
);
  import dnsq_pkg::*;

  logic signed [MUL_P_W-1:0] p_d;
  logic signed [MUL_P_W-1:0] p_q;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;
endmodule

FILE: sv/dnsq_hist.sv
// Error history shift lines of both channels with a tap read port.
module dnsq_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          shift_i,
  input  logic                          lane_i,
  input  dnsq_pkg::err_t                err_i,
  input  logic [dnsq_pkg::TAP_W-1:0]    tap_i,
  output dnsq_pkg::err_t                rd_o
);
  import dnsq_pkg::*;

  err_t hist_q [2][TAP_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < TAP_COUNT; k++) begin
          hist_q[l][k] <= '0;
        end
      end
    end else if (clr_i) begin
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < TAP_COUNT; k++) begin
          hist_q[l][k] <= '0;
        end
      end
    end else if (shift_i) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) begin
        hist_q[lane_i][k] <= hist_q[lane_i][k+1];
      end
      hist_q[lane_i][TAP_COUNT-1] <= err_i;
    end
  end

  assign rd_o = hist_q[lane_i][tap_i];
endmodule

FILE: sv/dnsq_ctrl.sv
// Sequencer that steps both channels and the feedback filter through the shared multiplier.
module dnsq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           ns_en_i,
  input  logic           out_free_i,
  output logic           in_ready_o,
  output dnsq_pkg::ctl_t ctl_o
);
  import dnsq_pkg::*;

  st_e              st_q, st_d;
  logic             lane_q, lane_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      lane_q <= 1'b0;
      tap_q  <= '0;
    end else begin
      st_q   <= st_d;
      lane_q <= lane_d;
      tap_q  <= tap_d;
    end
  end

  always_comb begin
    st_d   = st_q;
    lane_d = lane_q;
    tap_d  = tap_q;
    case (st_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          st_d   = ST_MUL_S;
          lane_d = 1'b0;
        end
      end
      ST_MUL_S: st_d = ST_DIV_K;
      ST_DIV_K: st_d = ST_DIV_C;
      ST_DIV_C: st_d = ST_DITH;
      ST_DITH:  st_d = ST_RND;
      ST_RND: begin
        if (!lane_q) begin
          lane_d = 1'b1;
          st_d   = ST_MUL_S;
        end else if (ns_en_i) begin
          lane_d = 1'b0;
          tap_d  = '0;
          st_d   = ST_MAC;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_MAC: begin
        if (tap_q == TAP_LAST) begin
          st_d = ST_MAC_TAIL;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_MAC_TAIL: st_d = ST_FB;
      ST_FB: begin
        if (!lane_q) begin
          lane_d = 1'b1;
          tap_d  = '0;
          st_d   = ST_MAC;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (st_q == ST_IDLE);
  assign ctl_o      = '{st: st_q, lane: lane_q, tap: tap_q};
endmodule

FILE: sv/dither_noise_shaped_quantizer_core.sv
// Top level of the stereo dither and noise-shaping quantizer.
//
//   Channel   Dir  Beat contents
//   frame_i   in   left/right sample, four dither values, block_end
//   result_o  out  left_out, right_out, frame_last
//   cfg_i     in   register index, write data
//
// Each channel of a frame is scaled, dithered and rounded, and with shaping on filtered too;
// every product, including the 9-tap filter of each channel, passes one per cycle through
// the single shared multiplier. Reset is asynchronous and clears the sequencer, the
// configuration registers, both histories and both feedback terms. A result waiting on
// result_o does not block the next frame, which only stalls at its own hand-over.
module dither_noise_shaped_quantizer_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  dnsq_frame_if.sink     frame_i,
  dnsq_result_if.source  result_o,
  dnsq_cfg_if.sink       cfg_i
);
  import dnsq_pkg::*;

  logic              ns_en_q;
  logic              dith_en_q;
  logic [GAIN_W-1:0] gain_q;
  logic [RATE_W-1:0] rate_q;
  logic              cfg_fire;
  logic              cfg_hit;

  logic signed [SAMPLE_W-1:0] smp_q [2];
  logic [DITHER_W-1:0]        da_q [2];
  logic [DITHER_W-1:0]        db_q [2];
  logic                       last_q;
  logic                       in_fire;

  ctl_t ctl;
  logic out_free;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic signed [MUL_P_W-1:0] prod;

  logic signed [SAMPLE_W-1:0] smp_sel;
  logic [DITH_SUM_W-1:0]      dsum;
  logic [DITH_M_W-1:0]        dm;
  logic [DITH_M_W:0]          drem;
  logic [DITH_Q_W-1:0]        dq;
  logic signed [XW-1:0]       dith;

  logic signed [FB_W-1:0]     fb_q [2];
  logic signed [XW-1:0]       xn_q, xn_d;
  logic signed [XW-1:0]       xd_q, xd_d;
  logic [DITH_Q_W-1:0]        q0_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [R_W-1:0]      r_full;
  logic signed [R_W-1:0]      lim;
  logic signed [R_W-1:0]      r_clamp;
  logic signed [XW-1:0]       err_full;
  err_t                       err_val;
  err_t                       hist_rd;
  logic signed [OUT_W-1:0]    res_q [2];
  logic signed [FB_W-1:0]     fb_new;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_l_q;
  logic signed [OUT_W-1:0] out_r_q;
  logic                    out_last_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    case (cfg_i.index)
      REG_NS_EN, REG_DITH_EN, REG_GAIN, REG_RATE: cfg_hit = cfg_fire;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_en_q   <= 1'b0;
      dith_en_q <= 1'b0;
      gain_q    <= GAIN_RESET;
      rate_q    <= RATE_NONE;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        REG_NS_EN:   ns_en_q   <= cfg_i.data[0];
        REG_DITH_EN: dith_en_q <= cfg_i.data[0];
        REG_GAIN:    gain_q    <= cfg_i.data[GAIN_W-1:0];
        REG_RATE:    rate_q    <= cfg_i.data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || result_o.ready;
  assign in_fire       = frame_i.valid && frame_i.ready;

  dnsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .ns_en_i    (ns_en_q),
    .out_free_i (out_free),
    .in_ready_o (frame_i.ready),
    .ctl_o      (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q[0] <= frame_i.left_sample;
      smp_q[1] <= frame_i.right_sample;
      da_q[0]  <= frame_i.left_dither_a;
      db_q[0]  <= frame_i.left_dither_b;
      da_q[1]  <= frame_i.right_dither_a;
      db_q[1]  <= frame_i.right_dither_b;
      last_q   <= frame_i.block_end;
    end
  end

  // Samples of magnitude 1.2 or more count as zero.
  always_comb begin
    smp_sel = smp_q[ctl.lane];
    if (!(smp_sel < SAMPLE_LIMIT && smp_sel > -SAMPLE_LIMIT)) begin
      smp_sel = '0;
    end
  end

  assign dsum = DITH_SUM_W'(da_q[ctl.lane]) + DITH_SUM_W'(db_q[ctl.lane]);
  assign dm   = DITH_M_W'({dsum, {DITH_PRE{1'b0}}}) + DITH_M_W'(DITH_BIAS);
  assign drem = {1'b0, dm} - prod[DITH_M_W:0];
  assign dq   = q0_q + DITH_Q_W'(drem >= (DITH_M_W + 1)'(DITH_DIVISOR));
  assign dith = $signed(XW'(dq)) - XW'(DITH_ONE);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (ctl.st)
      ST_MUL_S: begin
        mul_a = MUL_A_W'(smp_sel);
        mul_b = $signed(MUL_B_W'(gain_q));
      end
      ST_DIV_K: begin
        mul_a = $signed(MUL_A_W'(dm));
        mul_b = $signed(MUL_B_W'(DITH_RECIP));
      end
      ST_DIV_C: begin
        mul_a = $signed(MUL_A_W'(prod[DITH_RCP_SHIFT +: DITH_Q_W]));
        mul_b = $signed(MUL_B_W'(DITH_DIVISOR));
      end
      ST_MAC: begin
        mul_a = MUL_A_W'(coef_at(rate_q, ctl.tap));
        mul_b = MUL_B_W'(hist_rd);
      end
      default: mul_en = 1'b0;
    endcase
  end

  dnsq_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign xn_d = XW'(rnd_shr(64'(prod), PROD_SHIFT))
              + (ns_en_q ? XW'(fb_q[ctl.lane]) : XW'(0));
  assign xd_d = xn_q + (dith_en_q ? dith : XW'(0));

  assign r_full   = R_W'(rnd_shr(64'(xd_q), FRAC_BITS));
  assign err_full = (XW'(r_full) <<< FRAC_BITS) - xn_q;
  assign err_val  = err_full[ERR_W-1:0];
  assign lim      = $signed(R_W'(gain_q[GAIN_W-1 -: LIMIT_W]));

  always_comb begin
    r_clamp = r_full;
    if (r_full > lim) begin
      r_clamp = lim;
    end else if (r_full < -lim) begin
      r_clamp = -lim;
    end
  end

  always_comb begin
    acc_d = acc_q;
    case (ctl.st)
      ST_MAC: begin
        if (ctl.tap == '0) begin
          acc_d = '0;
        end else begin
          acc_d = acc_q + ACC_W'(prod);
        end
      end
      ST_MAC_TAIL: acc_d = acc_q + ACC_W'(prod);
      default: acc_d = acc_q;
    endcase
  end

  assign fb_new = FB_W'(rnd_shr(64'(acc_q), COEF_BITS));

  always_ff @(posedge clk_i) begin
    if (ctl.st == ST_DIV_K) begin
      xn_q <= xn_d;
    end
    if (ctl.st == ST_DIV_C) begin
      q0_q <= prod[DITH_RCP_SHIFT +: DITH_Q_W];
    end
    if (ctl.st == ST_DITH) begin
      xd_q <= xd_d;
    end
    if (ctl.st == ST_RND) begin
      res_q[ctl.lane] <= OUT_W'(r_clamp);
    end
    acc_q <= acc_d;
  end

  dnsq_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (cfg_hit),
    .shift_i ((ctl.st == ST_RND) && ns_en_q),
    .lane_i  (ctl.lane),
    .err_i   (err_val),
    .tap_i   (ctl.tap),
    .rd_o    (hist_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q[0] <= '0;
      fb_q[1] <= '0;
    end else if (cfg_hit) begin
      fb_q[0] <= '0;
      fb_q[1] <= '0;
    end else if (ctl.st == ST_FB && ns_en_q) begin
      fb_q[ctl.lane] <= fb_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.st == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.st == ST_DONE && out_free) begin
      out_l_q    <= res_q[0];
      out_r_q    <= res_q[1];
      out_last_q <= last_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.left_out   = out_l_q;
  assign result_o.right_out  = out_r_q;
  assign result_o.frame_last = out_last_q;

  a_fire_starts_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (ctl.st == ST_MUL_S) && !ctl.lane)
    else $error("accepted frame did not start on the left channel");

  a_cfg_clears_fb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (fb_q[0] == '0) && (fb_q[1] == '0))
    else $error("register write did not clear the feedback terms");

  a_fb_hold_unshaped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ns_en_q && !cfg_hit |=> $stable(fb_q[0]) && $stable(fb_q[1]))
    else $error("feedback changed with shaping off");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.st == ST_DONE))
    else $error("result appeared outside the hand-over step");
endmodule
